/* design/vvfc_pkg.sv */
`timescale 1ns / 1ps

package vvfc_pkg;

  // Default geometry
  localparam int CHUNK_EDGE_DEF = 16;
  localparam int TYPE_COUNT_DEF = 4;

  // Fixed field widths
  localparam int COORD_W = 4;
  localparam int TYPE_W  = 2;
  localparam int OP_W    = 2;
  localparam int DIR_W   = 3;
  localparam int MASK_W  = 4;
  localparam int VB_W    = 17;
  localparam int DIR_N   = 6;
  localparam int STEP_W  = 3;

  localparam logic [VB_W-1:0] VB_MAX  = {VB_W{1'b1}};
  localparam logic [VB_W-1:0] VB_STEP = VB_W'(4);

  localparam logic [MASK_W-1:0] ENABLE_RST = {MASK_W{1'b1}};

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_SCAN  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Face directions
  localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
  localparam logic [DIR_W-1:0] DIR_PY = 3'd1;
  localparam logic [DIR_W-1:0] DIR_NX = 3'd2;
  localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
  localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
  localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

  // Read steps: the center cell, then one per direction
  localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LAST   = 3'd6;

  typedef struct packed {
    logic              sweep;
    logic              write;
    logic              clear_cnt;
    logic              capture;
    logic              read;
    logic [STEP_W-1:0] step;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic scan_ok;
    logic face_avail;
    logic face_last;
  } status_t;

endpackage

/* design/vvfc_ctrl.sv */
`timescale 1ns / 1ps

module vvfc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [vvfc_pkg::OP_W-1:0]       in_operation,
  input  vvfc_pkg::status_t               status,
  output vvfc_pkg::cmd_t                  cmd,
  output logic                            busy
);

  typedef enum logic [4:0] {
    ST_SWEEP = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [vvfc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd           = '0;
    cmd.step      = step_r;
    unique case (state_r)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == vvfc_pkg::OP_WRITE) begin
            cmd.write = 1'b1;
          end else if (in_operation == vvfc_pkg::OP_CLEAR) begin
            cmd.clear_cnt = 1'b1;
          end else if (in_operation == vvfc_pkg::OP_SCAN && status.scan_ok) begin
            cmd.capture = 1'b1;
            step_nxt    = vvfc_pkg::STEP_CENTER;
            state_nxt   = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.read = 1'b1;
        if (step_r == vvfc_pkg::STEP_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (!status.face_avail || status.face_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      step_r  <= vvfc_pkg::STEP_CENTER;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

/* design/vvfc_dp.sv */
`timescale 1ns / 1ps

module vvfc_dp #(
  parameter int CHUNK_EDGE = vvfc_pkg::CHUNK_EDGE_DEF,
  parameter int TYPE_COUNT = vvfc_pkg::TYPE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vvfc_pkg::cmd_t                    cmd,
  output vvfc_pkg::status_t                 status,
  input  logic                              cfg_we,
  input  logic [vvfc_pkg::MASK_W-1:0]       cfg_wdata,
  input  logic [vvfc_pkg::COORD_W-1:0]      in_cell_x,
  input  logic [vvfc_pkg::COORD_W-1:0]      in_cell_y,
  input  logic [vvfc_pkg::COORD_W-1:0]      in_cell_z,
  input  logic [vvfc_pkg::TYPE_W-1:0]       in_block_type,
  output logic                              out_strobe,
  output logic [vvfc_pkg::COORD_W-1:0]      out_face_x,
  output logic [vvfc_pkg::COORD_W-1:0]      out_face_y,
  output logic [vvfc_pkg::COORD_W-1:0]      out_face_z,
  output logic [vvfc_pkg::DIR_W-1:0]        out_face_direction,
  output logic [vvfc_pkg::TYPE_W-1:0]       out_face_type,
  output logic [vvfc_pkg::VB_W-1:0]         out_vertex_base,
  output logic                              out_last_face
);

  localparam int CELLS = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
  localparam int AW    = $clog2(CELLS);
  localparam int PLANE = CHUNK_EDGE * CHUNK_EDGE;
  localparam int CNT_N = (TYPE_COUNT < 4) ? TYPE_COUNT : 4;
  localparam int CIW   = $clog2(CNT_N);
  localparam int NW    = vvfc_pkg::COORD_W + 1;

  // Block store
  logic [vvfc_pkg::TYPE_W-1:0]   store_mem [CELLS];
  logic [vvfc_pkg::TYPE_W-1:0]   rdata_r;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [vvfc_pkg::TYPE_W-1:0]   mem_wdata;
  logic [AW-1:0]                 mem_raddr;

  logic [AW-1:0]                 sweep_r;
  logic [vvfc_pkg::MASK_W-1:0]   enabled_r;

  // Scan context
  logic [vvfc_pkg::COORD_W-1:0]  cx_r, cy_r, cz_r;
  logic [vvfc_pkg::TYPE_W-1:0]   ctype_r;
  logic [vvfc_pkg::DIR_N-1:0]    mask_r;
  logic                          rd_vld_r;
  logic [vvfc_pkg::STEP_W-1:0]   rd_step_r;
  logic                          rd_oob_r;

  logic [vvfc_pkg::VB_W-1:0]     cnt_r [CNT_N];

  logic                          in_range;
  logic                          type_ok;
  logic                          write_ok;
  logic [AW-1:0]                 in_addr;

  logic [NW-1:0]                 nx, ny, nz;
  logic                          n_oob;
  logic [AW-1:0]                 n_addr;

  logic                          ctype_ok;
  logic [vvfc_pkg::DIR_W-1:0]    sel_dir;
  logic [vvfc_pkg::DIR_N-1:0]    rest_mask;
  logic [CIW-1:0]                cidx;
  logic [vvfc_pkg::VB_W-1:0]     base;
  logic [vvfc_pkg::VB_W-1:0]     base_nxt;

  // Input cell checks
  assign in_range = (32'(in_cell_x) < CHUNK_EDGE) && (32'(in_cell_y) < CHUNK_EDGE)
                    && (32'(in_cell_z) < CHUNK_EDGE);
  assign type_ok  = (in_block_type == '0) ||
                    ((32'(in_block_type) < TYPE_COUNT) && enabled_r[in_block_type]);
  assign write_ok = in_range && type_ok;
  assign in_addr  = AW'(AW'(in_cell_x) * AW'(PLANE) + AW'(in_cell_y) * AW'(CHUNK_EDGE)
                        + AW'(in_cell_z));

  // Neighbor coordinate for the current read step; step 0 is the center
  always_comb begin
    nx    = NW'(cx_r);
    ny    = NW'(cy_r);
    nz    = NW'(cz_r);
    n_oob = 1'b0;
    if (cmd.step != vvfc_pkg::STEP_CENTER) begin
      case (cmd.step - 1'b1)
        vvfc_pkg::DIR_PX: begin
          nx    = NW'(cx_r) + 1'b1;
          n_oob = (32'(nx) >= CHUNK_EDGE);
        end
        vvfc_pkg::DIR_PY: begin
          ny    = NW'(cy_r) + 1'b1;
          n_oob = (32'(ny) >= CHUNK_EDGE);
        end
        vvfc_pkg::DIR_NX: begin
          nx    = NW'(cx_r) - 1'b1;
          n_oob = (cx_r == '0);
        end
        vvfc_pkg::DIR_NY: begin
          ny    = NW'(cy_r) - 1'b1;
          n_oob = (cy_r == '0);
        end
        vvfc_pkg::DIR_PZ: begin
          nz    = NW'(cz_r) + 1'b1;
          n_oob = (32'(nz) >= CHUNK_EDGE);
        end
        vvfc_pkg::DIR_NZ: begin
          nz    = NW'(cz_r) - 1'b1;
          n_oob = (cz_r == '0);
        end
        default: begin
          n_oob = 1'b1;
        end
      endcase
    end
    // outside neighbors read the center instead; the data is ignored
    if (n_oob) begin
      nx = NW'(cx_r);
      ny = NW'(cy_r);
      nz = NW'(cz_r);
    end
  end

  assign n_addr = AW'(AW'(nx) * AW'(PLANE) + AW'(ny) * AW'(CHUNK_EDGE) + AW'(nz));

  // Memory port select
  assign mem_we    = cmd.sweep || (cmd.write && write_ok);
  assign mem_waddr = cmd.sweep ? sweep_r : in_addr;
  assign mem_wdata = cmd.sweep ? '0 : in_block_type;
  assign mem_raddr = n_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= store_mem[mem_raddr];
  end

  // Clearing sweep address and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r   <= '0;
      enabled_r <= vvfc_pkg::ENABLE_RST;
    end else begin
      if (cmd.sweep) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cfg_we) begin
        enabled_r <= cfg_wdata;
      end
    end
  end

  // Capture scan cell, collect the exposure mask
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cx_r <= in_cell_x;
      cy_r <= in_cell_y;
      cz_r <= in_cell_z;
    end
    rd_step_r <= cmd.step;
    rd_oob_r  <= n_oob;
    if (rd_vld_r) begin
      if (rd_step_r == vvfc_pkg::STEP_CENTER) begin
        ctype_r <= rdata_r;
      end else begin
        mask_r[rd_step_r - 1'b1] <= rd_oob_r || (rdata_r == '0);
      end
    end
    if (cmd.emit && status.face_avail) begin
      mask_r[sel_dir] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.read;
    end
  end

  // Pick the lowest pending direction
  always_comb begin
    sel_dir = '0;
    for (int i = vvfc_pkg::DIR_N - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel_dir = vvfc_pkg::DIR_W'(i);
      end
    end
  end

  assign rest_mask = mask_r & ~(vvfc_pkg::DIR_N'(1) << sel_dir);
  assign ctype_ok  = (ctype_r != '0) && (32'(ctype_r) < TYPE_COUNT);
  assign cidx      = CIW'(ctype_r);
  assign base      = cnt_r[cidx];
  assign base_nxt  = (base > vvfc_pkg::VB_MAX - vvfc_pkg::VB_STEP) ? vvfc_pkg::VB_MAX
                                                                  : base + vvfc_pkg::VB_STEP;

  // Vertex counters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_cnt) begin
      for (int i = 0; i < CNT_N; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cmd.emit && status.face_avail) begin
      cnt_r[cidx] <= base_nxt;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe    <= 1'b0;
      out_last_face <= 1'b0;
    end else begin
      out_strobe    <= cmd.emit && status.face_avail;
      out_last_face <= cmd.emit && status.face_avail && status.face_last;
    end
    out_face_x         <= cx_r;
    out_face_y         <= cy_r;
    out_face_z         <= cz_r;
    out_face_direction <= sel_dir;
    out_face_type      <= ctype_r;
    out_vertex_base    <= base;
  end

  assign status.sweep_last = (sweep_r == AW'(CELLS - 1));
  assign status.scan_ok    = in_range;
  assign status.face_avail = ctype_ok && (mask_r != '0);
  assign status.face_last  = (rest_mask == '0);

  // Checks
  a_type_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_face_type != '0)
    else $error("face emitted for an empty cell");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_face |-> out_strobe)
    else $error("last face flag without a word");

  a_end_of_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_face |=> !out_strobe)
    else $error("word after the last face of a scan");

  a_faces_packed: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_face |=> out_strobe)
    else $error("gap inside a scan's face burst");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_face_direction <= vvfc_pkg::DIR_NZ)
    else $error("face direction out of range");

endmodule

/* design/voxel_visible_face_culler.sv */
`timescale 1ns / 1ps
// A write or a counter clear completes at its accept edge; busy stays low.
// A scan reads the center and six neighbors, one per cycle, through the single read port,
// then drains; its face words follow from the result register, back to back.
// Out-of-chunk scans and op 3 are dropped in idle; busy stays low.
// Reset: busy while the store is swept clear. The receiver cannot stall results.
module voxel_visible_face_culler #(
  parameter int CHUNK_EDGE = vvfc_pkg::CHUNK_EDGE_DEF,
  parameter int TYPE_COUNT = vvfc_pkg::TYPE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [vvfc_pkg::OP_W-1:0]         in_operation,
  input  logic [vvfc_pkg::COORD_W-1:0]      in_cell_x,
  input  logic [vvfc_pkg::COORD_W-1:0]      in_cell_y,
  input  logic [vvfc_pkg::COORD_W-1:0]      in_cell_z,
  input  logic [vvfc_pkg::TYPE_W-1:0]       in_block_type,
  input  logic                              cfg_we,
  input  logic [vvfc_pkg::MASK_W-1:0]       cfg_wdata,
  output logic                              out_strobe,
  output logic [vvfc_pkg::COORD_W-1:0]      out_face_x,
  output logic [vvfc_pkg::COORD_W-1:0]      out_face_y,
  output logic [vvfc_pkg::COORD_W-1:0]      out_face_z,
  output logic [vvfc_pkg::DIR_W-1:0]        out_face_direction,
  output logic [vvfc_pkg::TYPE_W-1:0]       out_face_type,
  output logic [vvfc_pkg::VB_W-1:0]         out_vertex_base,
  output logic                              out_last_face
);

  vvfc_pkg::cmd_t    cmd;
  vvfc_pkg::status_t status;

  vvfc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  vvfc_dp #(
    .CHUNK_EDGE (CHUNK_EDGE),
    .TYPE_COUNT (TYPE_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_cell_x          (in_cell_x),
    .in_cell_y          (in_cell_y),
    .in_cell_z          (in_cell_z),
    .in_block_type      (in_block_type),
    .out_strobe         (out_strobe),
    .out_face_x         (out_face_x),
    .out_face_y         (out_face_y),
    .out_face_z         (out_face_z),
    .out_face_direction (out_face_direction),
    .out_face_type      (out_face_type),
    .out_vertex_base    (out_vertex_base),
    .out_last_face      (out_last_face)
  );

endmodule

/* tb/tb_voxel_visible_face_culler.sv */
`timescale 1ns / 1ps

module tb_voxel_visible_face_culler;

  localparam int CHUNK         = vvfc_pkg::CHUNK_EDGE_DEF;
  localparam int TYPES         = vvfc_pkg::TYPE_COUNT_DEF;
  localparam int PERIOD        = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 20;     // longest scan emits six faces
  localparam int STALL_LIMIT   = 20000;  // must outlast the reset sweep
  localparam int BURST_WORDS   = 26;
  localparam int CALM_SCANS    = 6;      // 6 faces each on an isolated corner
  localparam logic [vvfc_pkg::OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [vvfc_pkg::OP_W-1:0]    op;
    logic [vvfc_pkg::COORD_W-1:0] x;
    logic [vvfc_pkg::COORD_W-1:0] y;
    logic [vvfc_pkg::COORD_W-1:0] z;
    logic [vvfc_pkg::TYPE_W-1:0]  btype;
  } voxel_cmd_t;

  typedef struct packed {
    logic [vvfc_pkg::COORD_W-1:0] x;
    logic [vvfc_pkg::COORD_W-1:0] y;
    logic [vvfc_pkg::COORD_W-1:0] z;
    logic [vvfc_pkg::DIR_W-1:0]   dir;
    logic [vvfc_pkg::TYPE_W-1:0]  ftype;
    logic [vvfc_pkg::VB_W-1:0]    base;
    logic                         last;
  } face_t;

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          start         = 1'b0;
  logic                          busy;
  logic [vvfc_pkg::OP_W-1:0]     in_operation  = OP_NONE;
  logic [vvfc_pkg::COORD_W-1:0]  in_cell_x     = '0;
  logic [vvfc_pkg::COORD_W-1:0]  in_cell_y     = '0;
  logic [vvfc_pkg::COORD_W-1:0]  in_cell_z     = '0;
  logic [vvfc_pkg::TYPE_W-1:0]   in_block_type = '0;
  logic                          cfg_we        = 1'b0;
  logic [vvfc_pkg::MASK_W-1:0]   cfg_wdata     = '0;
  logic                          out_strobe;
  logic [vvfc_pkg::COORD_W-1:0]  out_face_x;
  logic [vvfc_pkg::COORD_W-1:0]  out_face_y;
  logic [vvfc_pkg::COORD_W-1:0]  out_face_z;
  logic [vvfc_pkg::DIR_W-1:0]    out_face_direction;
  logic [vvfc_pkg::TYPE_W-1:0]   out_face_type;
  logic [vvfc_pkg::VB_W-1:0]     out_vertex_base;
  logic                          out_last_face;

  // Shadow state of the culler
  logic [vvfc_pkg::TYPE_W-1:0] voxel_model [CHUNK][CHUNK][CHUNK] = '{default: '0};
  logic [vvfc_pkg::VB_W-1:0]   vcount_model [TYPES] = '{default: '0};
  logic [vvfc_pkg::MASK_W-1:0] mask_model = vvfc_pkg::ENABLE_RST;

  voxel_cmd_t cmd_backlog[$];
  face_t      expected_faces[$];

  bit took_word      = 1'b0;
  bit calm           = 1'b0;
  int gap_left       = 0;
  int stall_cycles   = 0;
  int mismatch_count = 0;

  voxel_visible_face_culler dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_cell_x          (in_cell_x),
    .in_cell_y          (in_cell_y),
    .in_cell_z          (in_cell_z),
    .in_block_type      (in_block_type),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_strobe         (out_strobe),
    .out_face_x         (out_face_x),
    .out_face_y         (out_face_y),
    .out_face_z         (out_face_z),
    .out_face_direction (out_face_direction),
    .out_face_type      (out_face_type),
    .out_vertex_base    (out_vertex_base),
    .out_last_face      (out_last_face)
  );

  always #(PERIOD / 2) clk = ~clk;

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Neighbor in direction dir is empty or outside the chunk
  function automatic bit face_open(voxel_cmd_t c, logic [vvfc_pkg::DIR_W-1:0] dir);
    int nx;
    int ny;
    int nz;
    nx = int'(c.x);
    ny = int'(c.y);
    nz = int'(c.z);
    case (dir)
      vvfc_pkg::DIR_PX: nx = nx + 1;
      vvfc_pkg::DIR_PY: ny = ny + 1;
      vvfc_pkg::DIR_NX: nx = nx - 1;
      vvfc_pkg::DIR_NY: ny = ny - 1;
      vvfc_pkg::DIR_PZ: nz = nz + 1;
      vvfc_pkg::DIR_NZ: nz = nz - 1;
      default: ;
    endcase
    if (nx < 0 || ny < 0 || nz < 0 || nx >= CHUNK || ny >= CHUNK || nz >= CHUNK) begin
      return 1'b1;
    end
    return voxel_model[nx][ny][nz] == '0;
  endfunction

  // Apply one accepted word to the shadow state and queue the faces it exposes
  task automatic cull_faces(voxel_cmd_t c);
    logic [vvfc_pkg::TYPE_W-1:0] kind;
    logic [vvfc_pkg::VB_W-1:0]   base;
    int                          exposed;
    int                          emitted;
    face_t                       f;
    exposed = 0;
    emitted = 0;
    case (c.op)
      vvfc_pkg::OP_WRITE: begin
        if (c.btype == '0 || mask_model[c.btype]) begin
          voxel_model[c.x][c.y][c.z] = c.btype;
        end
      end
      vvfc_pkg::OP_CLEAR: begin
        foreach (vcount_model[i]) vcount_model[i] = '0;
      end
      vvfc_pkg::OP_SCAN: begin
        kind = voxel_model[c.x][c.y][c.z];
        if (kind != '0) begin
          for (int d = 0; d < vvfc_pkg::DIR_N; d++) begin
            if (face_open(c, vvfc_pkg::DIR_W'(d))) exposed++;
          end
          for (int d = 0; d < vvfc_pkg::DIR_N; d++) begin
            if (face_open(c, vvfc_pkg::DIR_W'(d))) begin
              base    = vcount_model[kind];
              emitted++;
              f.x     = c.x;
              f.y     = c.y;
              f.z     = c.z;
              f.dir   = vvfc_pkg::DIR_W'(d);
              f.ftype = kind;
              f.base  = base;
              f.last  = (emitted == exposed);
              expected_faces.push_back(f);
              // saturating add of one face's four corners
              vcount_model[kind] = (base > vvfc_pkg::VB_MAX - vvfc_pkg::VB_STEP) ?
                                   vvfc_pkg::VB_MAX : base + vvfc_pkg::VB_STEP;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Driver: present queued words, with random idle bursts between them
  always @(negedge clk) begin
    voxel_cmd_t nxt;
    if (rst_n && (!start || took_word)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (took_word && !calm && $urandom_range(0, 3) == 0) begin
        gap_left <= int'($urandom_range(0, 10));
        start <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        nxt = cmd_backlog.pop_front();
        start         <= 1'b1;
        in_operation  <= nxt.op;
        in_cell_x     <= nxt.x;
        in_cell_y     <= nxt.y;
        in_cell_z     <= nxt.z;
        in_block_type <= nxt.btype;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check face words, track config writes, predict accepted words
  always @(posedge clk) begin
    voxel_cmd_t taken;
    face_t      want;
    if (!rst_n) begin
      took_word    <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (out_strobe) begin
        if (expected_faces.size() == 0) begin
          flag_mismatch($sformatf("face word (%0d,%0d,%0d) dir %0d with nothing expected",
                                  out_face_x, out_face_y, out_face_z, out_face_direction));
        end else begin
          want = expected_faces.pop_front();
          check_field("face_x", 32'(out_face_x), 32'(want.x));
          check_field("face_y", 32'(out_face_y), 32'(want.y));
          check_field("face_z", 32'(out_face_z), 32'(want.z));
          check_field("face_direction", 32'(out_face_direction), 32'(want.dir));
          check_field("face_type", 32'(out_face_type), 32'(want.ftype));
          check_field("vertex_base", 32'(out_vertex_base), 32'(want.base));
          check_field("last_face", 32'(out_last_face), 32'(want.last));
        end
      end
      if (cfg_we) mask_model = cfg_wdata;
      if (start && !busy) begin
        taken.op    = in_operation;
        taken.x     = in_cell_x;
        taken.y     = in_cell_y;
        taken.z     = in_cell_z;
        taken.btype = in_block_type;
        cull_faces(taken);
      end
      took_word <= start && !busy;
      if ((start && !busy) || out_strobe || cfg_we) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Watchdog
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic push_cmd(logic [vvfc_pkg::OP_W-1:0] op, int x, int y, int z, int bt);
    voxel_cmd_t c;
    c.op    = op;
    c.x     = vvfc_pkg::COORD_W'(x);
    c.y     = vvfc_pkg::COORD_W'(y);
    c.z     = vvfc_pkg::COORD_W'(z);
    c.btype = vvfc_pkg::TYPE_W'(bt);
    cmd_backlog.push_back(c);
  endtask

  // Wait until the block is idle with nothing outstanding
  task automatic settle();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || start || busy || expected_faces.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mask(logic [vvfc_pkg::MASK_W-1:0] m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Cluster origin: low edge, high edge or anywhere
  function automatic int cluster_origin();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return CHUNK - 3;
      default: return int'($urandom_range(0, CHUNK - 3));
    endcase
  endfunction

  function automatic int near_coord(int o);
    if ($urandom_range(0, 99) < 85) return o + int'($urandom_range(0, 2));
    return int'($urandom_range(0, CHUNK - 1));
  endfunction

  // Random words, mostly writes and scans packed into a small cluster
  task automatic random_burst(int n);
    int ox;
    int oy;
    int oz;
    int pick;
    logic [vvfc_pkg::OP_W-1:0] op;
    ox = cluster_origin();
    oy = cluster_origin();
    oz = cluster_origin();
    repeat (n) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 45)      op = vvfc_pkg::OP_WRITE;
      else if (pick < 90) op = vvfc_pkg::OP_SCAN;
      else if (pick < 95) op = vvfc_pkg::OP_CLEAR;
      else                op = OP_NONE;
      push_cmd(op, near_coord(ox), near_coord(oy), near_coord(oz),
               int'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    logic [vvfc_pkg::MASK_W-1:0] burst_masks [5];
    burst_masks = '{4'b0110, 4'b1010, 4'b0000, 4'b1101, 4'b1111};
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    settle();
    write_mask(vvfc_pkg::ENABLE_RST);

    // corner cells: every face open, several on the chunk boundary
    push_cmd(vvfc_pkg::OP_WRITE, 0, 0, 0, 1);
    push_cmd(vvfc_pkg::OP_SCAN, 0, 0, 0, 0);
    push_cmd(vvfc_pkg::OP_WRITE, 15, 15, 15, 3);
    push_cmd(vvfc_pkg::OP_SCAN, 15, 15, 15, 0);
    // covered faces are skipped
    push_cmd(vvfc_pkg::OP_WRITE, 1, 0, 0, 2);
    push_cmd(vvfc_pkg::OP_WRITE, 0, 1, 0, 2);
    push_cmd(vvfc_pkg::OP_WRITE, 0, 0, 1, 3);
    push_cmd(vvfc_pkg::OP_SCAN, 0, 0, 0, 0);
    push_cmd(vvfc_pkg::OP_SCAN, 1, 0, 0, 0);
    // empty cell, unused op code
    push_cmd(vvfc_pkg::OP_SCAN, 5, 5, 5, 0);
    push_cmd(OP_NONE, 0, 0, 0, 3);
    // clear counters, then bases restart
    push_cmd(vvfc_pkg::OP_CLEAR, 7, 7, 7, 0);
    push_cmd(vvfc_pkg::OP_SCAN, 15, 15, 15, 0);
    // erase a cell
    push_cmd(vvfc_pkg::OP_WRITE, 0, 0, 0, 0);
    push_cmd(vvfc_pkg::OP_SCAN, 0, 0, 0, 0);
    push_cmd(vvfc_pkg::OP_SCAN, 1, 0, 0, 0);
    // fully enclosed cell
    push_cmd(vvfc_pkg::OP_WRITE, 8, 8, 8, 1);
    push_cmd(vvfc_pkg::OP_WRITE, 9, 8, 8, 2);
    push_cmd(vvfc_pkg::OP_WRITE, 8, 9, 8, 3);
    push_cmd(vvfc_pkg::OP_WRITE, 7, 8, 8, 1);
    push_cmd(vvfc_pkg::OP_WRITE, 8, 7, 8, 2);
    push_cmd(vvfc_pkg::OP_WRITE, 8, 8, 9, 3);
    push_cmd(vvfc_pkg::OP_WRITE, 8, 8, 7, 1);
    push_cmd(vvfc_pkg::OP_SCAN, 8, 8, 8, 0);
    settle();

    // all types disabled: only erase gets through
    write_mask('0);
    push_cmd(vvfc_pkg::OP_WRITE, 5, 5, 5, 2);
    push_cmd(vvfc_pkg::OP_SCAN, 5, 5, 5, 0);
    push_cmd(vvfc_pkg::OP_WRITE, 9, 8, 8, 0);
    push_cmd(vvfc_pkg::OP_WRITE, 8, 8, 8, 3);
    push_cmd(vvfc_pkg::OP_SCAN, 8, 8, 8, 0);
    settle();

    foreach (burst_masks[i]) begin
      write_mask(i == 3 ? vvfc_pkg::MASK_W'($urandom_range(0, 15)) : burst_masks[i]);
      random_burst(BURST_WORDS);
      settle();
    end

    // no idling from here: back-to-back scans of an isolated corner
    calm = 1'b1;
    write_mask(vvfc_pkg::ENABLE_RST);
    push_cmd(vvfc_pkg::OP_WRITE, 15, 15, 0, 3);
    push_cmd(vvfc_pkg::OP_WRITE, 14, 15, 0, 0);
    push_cmd(vvfc_pkg::OP_WRITE, 15, 14, 0, 0);
    push_cmd(vvfc_pkg::OP_WRITE, 15, 15, 1, 0);
    push_cmd(vvfc_pkg::OP_CLEAR, 0, 0, 0, 0);
    repeat (CALM_SCANS) push_cmd(vvfc_pkg::OP_SCAN, 15, 15, 0, 0);
    push_cmd(vvfc_pkg::OP_CLEAR, 15, 15, 15, 3);
    push_cmd(vvfc_pkg::OP_SCAN, 15, 15, 0, 0);
    settle();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
